// File: rtl/md5sh_pkg.sv
// ============================================================================
// md5sh_pkg
// Shared types, round tables and helper functions for the MD5 stream hasher.
// ============================================================================
package md5sh_pkg;

    // Operation codes carried in the op field of an input transfer.
    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    // Input transfer: one message byte or a finish request.
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in;

    // Output transfer: one digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_DONE
    } t_state;

    // Controls from the sequencer to the compression core.
    typedef struct packed {
        logic       iv_load;
        logic       abcd_load;
        logic       wk_en;
        logic [5:0] wk_round;
        logic       rnd_en;
        logic [5:0] rnd_idx;
        logic       fold;
    } t_core_ctl;

    localparam int unsigned ROUNDS    = 64;
    localparam logic [6:0]  STEP_LAST = 7'(ROUNDS + 1);

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [3:0]  LEN_LO_WORD = 4'd14;
    localparam logic [3:0]  LEN_HI_WORD = 4'd15;

    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] round_const(input logic [5:0] r);
        return K_TABLE[r];
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        return ROT_TABLE[{r[5:4], r[1:0]}];
    endfunction

    // Message word used by round r; the index depends on the quarter r[5:4] and on r modulo 16.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] idx;
        case (r[5:4])
            2'd0:    idx = r[3:0];
            2'd1:    idx = 4'(r[3:0] * 4'd5 + 4'd1);
            2'd2:    idx = 4'(r[3:0] * 4'd3 + 4'd5);
            2'd3:    idx = 4'(r[3:0] * 4'd7);
            default: idx = r[3:0];
        endcase
        return idx;
    endfunction

endpackage

// File: rtl/md5sh_buf.sv
// ============================================================================
// md5sh_buf
// Sixteen-word message block memory, one write and one registered read port.
// ============================================================================
module md5sh_buf
    import md5sh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [3:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [3:0]  i_raddr,
    output logic [31:0] o_rdata
);

    logic [31:0] r_mem [16];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/md5sh_core.sv
// ============================================================================
// md5sh_core
// MD5 round unit: chaining value, working variables and one round per cycle while rnd_en is set.
// ============================================================================
module md5sh_core
    import md5sh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_core_ctl        i_ctl,
    input  logic [31:0]      i_rdata,
    output logic [3:0][31:0] o_chain
);

    logic [3:0][31:0] r_chain;
    logic [31:0]      r_a, r_b, r_c, r_d;
    logic [31:0]      r_wk;

    logic [31:0] f_val;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] b_new;

    // Round function of the current quarter.
    always_comb begin
        case (i_ctl.rnd_idx[5:4])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            2'd3:    f_val = r_c ^ (r_b | ~r_d);
            default: f_val = r_b ^ r_c ^ r_d;
        endcase
        sum      = r_a + f_val + r_wk;
        rot_wide = {sum, sum} << rot_amount(i_ctl.rnd_idx);
        b_new    = r_b + rot_wide[63:32];
    end

    // Message word plus round constant, one stage ahead of the round.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wk_en) begin
            r_wk <= i_rdata + round_const(i_ctl.wk_round);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.abcd_load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_ctl.rnd_en) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= b_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.iv_load) begin
            r_chain <= {IV_D, IV_C, IV_B, IV_A};
        end else if (i_ctl.fold) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
        end
    end

    assign o_chain = r_chain;

endmodule

// File: rtl/md5_stream_hasher.sv
// ============================================================================
// md5_stream_hasher
// MD5 digest of a byte stream, one byte per transfer, four digest words out.
// ============================================================================
// Input: a byte is taken whenever the hasher is idle; the 64th byte of a block
// holds the input off through the round loop, which runs behind a two-stage word
// fetch, and through the fold. A finish pads and compresses the last block, and a
// further one when the length does not fit, before its first digest word leaves.
// Reset is synchronous and active low and returns the hasher to an empty
// message; the block memory needs no clearing, since padding covers it.
module md5_stream_hasher
    import md5sh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // ------------------------------------------------------------------
    // Sequencer registers.
    // ------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [6:0]       r_step, n_step;    // compression step, 0..65 (66 while folding)
    logic [4:0]       r_ptr, n_ptr;      // next padding word to write, 16 = done
    logic             r_two, n_two;      // padding spills into an extra block
    logic             r_final, n_final;  // block in flight is the last one
    logic [60:0]      r_count, n_count;  // bytes absorbed, modulo 2^61
    logic [31:0]      r_word, n_word;    // word being assembled

    // Output registers: the digest is copied here so a new message can start
    // while the four words are still being transferred.
    logic [3:0][31:0] r_dig, n_dig;
    logic             r_obusy, n_obusy;
    logic [1:0]       r_oidx, n_oidx;

    logic             mem_we;
    logic [3:0]       mem_waddr;
    logic [31:0]      mem_wdata;
    logic [31:0]      mem_rdata;
    t_core_ctl        core_ctl;
    logic [3:0][31:0] chain;

    logic [5:0]       have;
    logic [63:0]      bit_len;
    logic [31:0]      abs_word;
    logic [31:0]      pad_word;
    logic             in_fire;

    assign have       = r_count[5:0];
    assign bit_len    = {r_count, 3'b000};
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // The word with the new byte merged in, and the word that closes the
    // message: pending bytes, then the marker byte, then zeros.
    always_comb begin
        abs_word = r_word;
        pad_word = '0;
        for (int k = 0; k < 4; k++) begin
            if (2'(k) == have[1:0]) begin
                abs_word[8*k +: 8] = i_in_data.data_byte;
                pad_word[8*k +: 8] = PAD_BYTE;
            end else if (2'(k) < have[1:0]) begin
                pad_word[8*k +: 8] = r_word[8*k +: 8];
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state and control.
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_ptr     = r_ptr;
        n_two     = r_two;
        n_final   = r_final;
        n_count   = r_count;
        n_word    = r_word;
        n_dig     = r_dig;
        n_obusy   = r_obusy;
        n_oidx    = r_oidx;
        mem_we    = 1'b0;
        mem_waddr = have[5:2];
        mem_wdata = abs_word;

        core_ctl           = '0;
        core_ctl.wk_round  = 6'(r_step - 7'd1);
        core_ctl.rnd_idx   = 6'(r_step - 7'd2);

        // Digest words leave one per output transfer.
        if (o_out_valid && i_out_ready) begin
            n_oidx = r_oidx + 2'd1;
            if (r_oidx == 2'd3) begin
                n_obusy = 1'b0;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    mem_we = 1'b1;
                    if (i_in_data.op == OP_ABSORB) begin
                        n_word  = abs_word;
                        n_count = r_count + 61'd1;
                        if (have == 6'd63) begin
                            n_state = ST_COMP;
                            n_step  = '0;
                            n_final = 1'b0;
                            n_two   = 1'b0;
                        end
                    end else begin
                        // Fewer than nine free bytes (the marker takes one):
                        // the length goes into a further block.
                        mem_wdata = pad_word;
                        n_ptr     = {1'b0, have[5:2]} + 5'd1;
                        n_two     = (have[5:3] == 3'b111);
                        n_final   = (have[5:3] != 3'b111);
                        n_state   = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_ptr[4]) begin
                    n_state = ST_COMP;
                    n_step  = '0;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ptr[3:0];
                    if (!r_two && r_ptr[3:0] == LEN_LO_WORD) begin
                        mem_wdata = bit_len[31:0];
                    end else if (!r_two && r_ptr[3:0] == LEN_HI_WORD) begin
                        mem_wdata = bit_len[63:32];
                    end else begin
                        mem_wdata = '0;
                    end
                    n_ptr = r_ptr + 5'd1;
                end
            end
            ST_COMP: begin
                // Step s fetches the word of round s, adds the constant for
                // round s-1 and runs round s-2.
                core_ctl.abcd_load = (r_step == 7'd0);
                core_ctl.wk_en     = (r_step != 7'd0) && (r_step <= 7'(ROUNDS));
                core_ctl.rnd_en    = (r_step >= 7'd2);
                n_step             = r_step + 7'd1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                core_ctl.fold = 1'b1;
                if (r_final) begin
                    n_state = ST_DONE;
                end else if (r_two) begin
                    n_two   = 1'b0;
                    n_final = 1'b1;
                    n_ptr   = '0;
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DONE: begin
                // Wait for the previous digest to drain, then hand this one
                // over and start a fresh message.
                if (!r_obusy) begin
                    n_dig            = chain;
                    n_obusy          = 1'b1;
                    n_oidx           = '0;
                    n_count          = '0;
                    core_ctl.iv_load = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_ptr   <= '0;
            r_two   <= 1'b0;
            r_final <= 1'b0;
            r_count <= '0;
            r_obusy <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ptr   <= n_ptr;
            r_two   <= n_two;
            r_final <= n_final;
            r_count <= n_count;
            r_obusy <= n_obusy;
            r_oidx  <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_dig  <= n_dig;
    end

    // ------------------------------------------------------------------
    // Block memory and round unit.
    // ------------------------------------------------------------------
    md5sh_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (msg_index(r_step[5:0])),
        .o_rdata (mem_rdata)
    );

    md5sh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_rdata (mem_rdata),
        .o_chain (chain)
    );

    assign o_out_valid            = r_obusy;
    assign o_out_data.digest_word = r_dig[r_oidx];
    assign o_out_data.word_index  = r_oidx;
    assign o_out_data.last_word   = (r_oidx == 2'd3);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The 64th byte of a block starts the compression right away.
    a_full_block_compresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.op == OP_ABSORB && have == 6'd63) |=> (r_state == ST_COMP))
        else $error("full block did not start compression");

    // A digest appears only when the final block has been folded.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_obusy) |-> ($past(r_state) == ST_DONE))
        else $error("digest output started outside the done state");

    // Every digest starts with word zero.
    a_out_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_obusy) |-> (r_oidx == 2'd0))
        else $error("digest output did not start at word zero");

    // Handing a digest over clears the byte count for the next message.
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_obusy) |=> (r_count == '0))
        else $error("byte count not cleared after digest");

endmodule

// File: tb/sv/tb_top.sv
// ============================================================================
// tb_top: self-checking testbench for md5_stream_hasher
// Streams messages into the hasher one byte per transfer, predicts the four
// digest words of every finish with an MD5 model kept inside the bench, and
// compares each received digest word field by field. Traffic runs through
// phases with no idling, a slow sender, a stalling receiver and light noise
// on both sides, plus one long receiver hold-off that backs up the input.
// ============================================================================
module tb_top;
    import md5sh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Directed rows plus at least this many random items, with at least this many
    // finished messages in the random part.
    localparam int unsigned RANDOM_ITEMS   = 240;
    localparam int unsigned RANDOM_DIGESTS = 5;
    // The receiver stops taking digest words for this many cycles once.
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned HOLD_AFTER     = 30;
    // Quiet tail after the last digest word, in which any further output is unexpected.
    localparam int unsigned DRAIN_CYCLES   = 200;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned REPORT_MAX     = 10;

    // Digest of the empty message, word 0 in the top 32 bits.
    localparam logic [127:0] EMPTY_DIGEST = 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec;

    // Per-round additive constants of MD5.
    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left-rotate amounts; each group of sixteen rounds cycles through four.
    localparam int unsigned ROT_BY [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // One row of stimulus. Where known is set, the digest that the finish
    // must produce is typed in; otherwise the bench's own MD5 model decides.
    typedef struct packed {
        t_op          op;
        logic [7:0]   data;
        logic         known;
        logic [127:0] digest;
    } t_row;

    localparam int unsigned DIRECTED_N = 19;

    localparam t_row DIRECTED [DIRECTED_N] = '{
        // Empty message straight after reset.
        '{OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
        // A second finish starts from scratch again; its data byte is ignored.
        '{OP_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},
        // The classic three-letter message.
        '{OP_ABSORB, 8'h61, 1'b0, '0},
        '{OP_ABSORB, 8'h62, 1'b0, '0},
        '{OP_ABSORB, 8'h63, 1'b0, '0},
        '{OP_FINISH, 8'h00, 1'b0, '0},
        // Extremes and alternating patterns of the data byte.
        '{OP_ABSORB, 8'h00, 1'b0, '0},
        '{OP_ABSORB, 8'hff, 1'b0, '0},
        '{OP_ABSORB, 8'h80, 1'b0, '0},
        '{OP_ABSORB, 8'h7f, 1'b0, '0},
        '{OP_ABSORB, 8'h55, 1'b0, '0},
        '{OP_ABSORB, 8'haa, 1'b0, '0},
        '{OP_ABSORB, 8'h01, 1'b0, '0},
        '{OP_ABSORB, 8'hfe, 1'b0, '0},
        '{OP_FINISH, 8'hff, 1'b0, '0},
        // A single all-ones byte, closed by a finish carrying a stray byte.
        '{OP_ABSORB, 8'hff, 1'b0, '0},
        '{OP_FINISH, 8'h5a, 1'b0, '0},
        // Back-to-back empty messages once more after real traffic.
        '{OP_FINISH, 8'h80, 1'b1, EMPTY_DIGEST},
        '{OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST}
    };

    // Message lengths that sit on the padding and block boundaries.
    localparam int unsigned EDGE_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    md5_stream_hasher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin : clock_gen
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus list, expected digest words and bookkeeping.
    // ------------------------------------------------------------------------
    t_row        msg_items [$];
    t_out        digest_words_due [$];
    int unsigned offer_idx  = 0;   // next row the sender will put on the bus
    int unsigned accept_idx = 0;   // rows the hasher has taken so far
    int unsigned mismatches = 0;
    int unsigned phase      = 0;   // traffic phase, follows the sender
    logic        hold_off   = 1'b0;

    // ------------------------------------------------------------------------
    // MD5 model: chaining value, byte counter and the block being filled.
    // ------------------------------------------------------------------------
    logic [31:0] chain_acc [4];
    logic [60:0] msg_bytes;
    logic [31:0] blk_words [16];

    function automatic void reset_hash_state();
        chain_acc[0] = 32'h67452301;
        chain_acc[1] = 32'hefcdab89;
        chain_acc[2] = 32'h98badcfe;
        chain_acc[3] = 32'h10325476;
        msg_bytes    = '0;
        foreach (blk_words[k]) blk_words[k] = '0;
    endfunction

    // Bytes fill the block lowest byte of each word first.
    function automatic void put_block_byte(input logic [5:0] pos, input logic [7:0] value);
        blk_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] = value;
    endfunction

    // Runs the 64 rounds over the current block and folds into the chain.
    function automatic void compress_block();
        logic [31:0] a, b, c, d, mix, spin, tmp;
        int unsigned g, s;
        a = chain_acc[0];
        b = chain_acc[1];
        c = chain_acc[2];
        d = chain_acc[3];
        for (int unsigned r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    mix = (b & c) | (~b & d);
                    g   = r;
                end
                1: begin
                    mix = (b & d) | (c & ~d);
                    g   = (5 * r + 1) % 16;
                end
                2: begin
                    mix = b ^ c ^ d;
                    g   = (3 * r + 5) % 16;
                end
                default: begin
                    mix = c ^ (b | ~d);
                    g   = (7 * r) % 16;
                end
            endcase
            s    = ROT_BY[(r / 16) * 4 + r % 4];
            spin = a + mix + SINE_K[r] + blk_words[g];
            tmp  = d;
            d    = c;
            c    = b;
            b    = b + ((spin << s) | (spin >> (32 - s)));
            a    = tmp;
        end
        chain_acc[0] += a;
        chain_acc[1] += b;
        chain_acc[2] += c;
        chain_acc[3] += d;
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        logic [5:0] pos;
        pos = msg_bytes[5:0];
        put_block_byte(pos, value);
        msg_bytes = msg_bytes + 61'd1;
        if (pos == 6'd63) begin
            compress_block();
        end
    endfunction

    // Pads and closes the message, then queues its four digest words. A
    // typed digest, where the row carries one, takes the place of the model's.
    function automatic void close_message(input logic known, input logic [127:0] typed);
        logic [63:0] bit_len;
        int unsigned pos;
        t_out        word;
        bit_len = {msg_bytes, 3'b000};
        pos     = msg_bytes[5:0];
        put_block_byte(6'(pos), 8'h80);
        pos++;
        // No room left for the length field: pad this block out and start
        // another one.
        if (pos > 56) begin
            while (pos < 64) begin
                put_block_byte(6'(pos), 8'h00);
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            put_block_byte(6'(pos), 8'h00);
            pos++;
        end
        blk_words[14] = bit_len[31:0];
        blk_words[15] = bit_len[63:32];
        compress_block();
        for (int unsigned i = 0; i < 4; i++) begin
            word.digest_word = known ? typed[127 - 32 * i -: 32] : chain_acc[i];
            word.word_index  = 2'(i);
            word.last_word   = (i == 3);
            digest_words_due.push_back(word);
        end
        reset_hash_state();
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender. A new row goes out only when the bus is free or the current
    // transfer completes at this edge, so valid and data stay put until taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : sender
        int unsigned idle_pct;
        t_row        row;
        idle_pct = (phase == 1) ? 86 : (phase == 3) ? 6 : 0;
        if (i_rst_n && (!i_in_valid || o_in_ready)) begin
            if (offer_idx < msg_items.size() && $urandom_range(99) >= idle_pct) begin
                row         = msg_items[offer_idx];
                i_in_valid <= 1'b1;
                i_in_data  <= t_in'{op: row.op, data_byte: row.data};
                offer_idx  <= offer_idx + 1;
                phase      <= (offer_idx * 4) / msg_items.size();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls per phase, plus the long hold-off.
    always @(posedge i_clk) begin : receiver
        int unsigned stall_pct;
        stall_pct = (phase == 2) ? 86 : (phase == 3) ? 6 : 0;
        if (i_rst_n) begin
            i_out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // Once some traffic has gone through, the receiver refuses digest words
    // for a long stretch. The sender keeps offering bytes, so the hasher has
    // to hold its output and back-pressure the input.
    initial begin : hold_burst
        int unsigned held;
        while (accept_idx < HOLD_AFTER) @(posedge i_clk);
        hold_off <= 1'b1;
        held = 0;
        while (held < HOLD_CYCLES) begin
            @(posedge i_clk);
            held++;
        end
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scoreboard. Both transfers are handled in one process so that a digest
    // word and a new input landing on the same edge are seen in a fixed order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_watch
        t_out want;
        t_row row;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (digest_words_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected digest word %h index %0d last %b",
                        o_out_data.digest_word, o_out_data.word_index,
                        o_out_data.last_word));
                end else begin
                    want = digest_words_due.pop_front();
                    if (o_out_data.digest_word !== want.digest_word ||
                        o_out_data.word_index !== want.word_index ||
                        o_out_data.last_word !== want.last_word) begin
                        flag_mismatch($sformatf(
                            "digest word: expected %h/%0d/%b, got %h/%0d/%b",
                            want.digest_word, want.word_index, want.last_word,
                            o_out_data.digest_word, o_out_data.word_index,
                            o_out_data.last_word));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                row = msg_items[accept_idx];
                accept_idx++;
                if (i_in_data.op == OP_ABSORB) begin
                    absorb_byte(i_in_data.data_byte);
                end else begin
                    close_message(row.known, row.digest);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("md5_stream_hasher: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the stimulus, release reset, wait for the last
    // digest word and a quiet tail, then report.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_row        row;
        int unsigned len;
        int unsigned random_finishes;
        reset_hash_state();
        foreach (DIRECTED[k]) msg_items.push_back(DIRECTED[k]);

        // Random messages: mostly short ones, some on the padding and block boundaries,
        // a few of any length.
        random_finishes = 0;
        while (msg_items.size() < DIRECTED_N + RANDOM_ITEMS ||
               random_finishes < RANDOM_DIGESTS) begin
            case ($urandom_range(8))
                0, 1, 2, 3, 4, 5: len = $urandom_range(12);
                6, 7:             len = EDGE_LEN[$urandom_range(9)];
                default:          len = $urandom_range(140);
            endcase
            repeat (len) begin
                row = '{OP_ABSORB, 8'($urandom_range(255)), 1'b0, '0};
                msg_items.push_back(row);
            end
            row = '{OP_FINISH, 8'($urandom_range(255)), 1'b0, '0};
            msg_items.push_back(row);
            random_finishes++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accept_idx < msg_items.size() || digest_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        // Anything the hasher sends after this point is unexpected.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("md5_stream_hasher: match");
        end else begin
            $display("md5_stream_hasher: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/md5sh_pkg.sv
rtl/md5sh_buf.sv
rtl/md5sh_core.sv
rtl/md5_stream_hasher.sv
tb/sv/tb_top.sv
